// ----- rtl/pid_controller_antiwindup_defines.svh -----
// Assertion macros used by pid_controller_antiwindup.sv. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PID_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/pid_pkg.sv -----
package pid_pkg;

  localparam int unsigned DefaultChannels = 2;

  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 23;
  localparam int unsigned ValueW  = 24;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = LimitW;

  localparam logic [GainW-1:0]  PropGainRst  = 16'd5120;
  localparam logic [GainW-1:0]  IntegGainRst = 16'd5120;
  localparam logic [GainW-1:0]  DerivGainRst = 16'd0;
  localparam logic [LimitW-1:0] IntegLimitRst = 23'd25600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_INTEG_GAIN  = 2'd1,
    CFG_DERIV_GAIN  = 2'd2,
    CFG_INTEG_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                     channel;
    logic signed [ValueW-1:0] measured;
    logic signed [ValueW-1:0] setpoint;
  } pid_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     integ_clamped;
  } pid_out_t;

endpackage

// ----- rtl/pid_controller_antiwindup.sv -----
// Two-channel PID regulator with integrator clamp. Each input beat carries a
// channel, a measured value and a setpoint (signed Q16.8); each produces one
// output beat with the drive (signed Q24.8, saturated) and a flag that is set
// when the integral would pass +/- integ_limit and was clamped. The block
// takes one beat per cycle while the output is not stalled: a beat is
// captured in an input register and, once the output register can take it,
// the error, integral update, three gain multiplies and the final sum and
// saturation are computed in one pass into the output register, where the
// channel's integral and last error are also written back. While the output
// beat waits, the input register holds one more beat and then input stalls.
// The user must write gains and the limit through the configuration port
// only while no beat is in flight; the block itself does not enforce this.
`include "pid_controller_antiwindup_defines.svh"

module pid_controller_antiwindup #(
  parameter int unsigned CHANNELS = pid_pkg::DefaultChannels
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pid_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pid_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pid_pkg::pid_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pid_pkg::pid_out_t                   out_data_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned VW   = pid_pkg::ValueW;
  localparam int unsigned GW   = pid_pkg::GainW;
  localparam int unsigned LW   = pid_pkg::LimitW;
  localparam int unsigned PW   = GW + 1 + VW;      // gain times 24-bit value
  localparam int unsigned DW   = GW + 1 + VW + 1;  // gain times 25-bit difference
  localparam int unsigned SW   = DW + 2;           // sum of three products
  localparam int unsigned QW   = SW - 8;           // sum after dropping 8 fraction bits
  localparam int unsigned OW   = pid_pkg::DriveW;

  // Configuration registers.
  logic [GW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [LW-1:0] integ_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= pid_pkg::PropGainRst;
      integ_gain_q  <= pid_pkg::IntegGainRst;
      deriv_gain_q  <= pid_pkg::DerivGainRst;
      integ_limit_q <= pid_pkg::IntegLimitRst;
    end else if (cfg_we_i) begin
      case (pid_pkg::cfg_idx_e'(cfg_idx_i))
        pid_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GW-1:0];
        pid_pkg::CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GW-1:0];
        pid_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i[GW-1:0];
        pid_pkg::CFG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Input and output registers.
  pid_pkg::pid_in_t  in_q;
  logic              in_valid_q;
  pid_pkg::pid_out_t out_q, out_d;
  logic              out_valid_q;
  logic              advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Per-channel state.
  logic signed [VW-1:0] last_err_q [CHANNELS];
  logic signed [VW-1:0] integ_q    [CHANNELS];
  logic [IdxW-1:0]      ch_idx;

  assign ch_idx = (CHANNELS == 1) ? '0 : IdxW'(in_q.channel);

  logic signed [VW:0]   err_full;
  logic signed [VW-1:0] err;
  logic signed [VW:0]   acc_full;
  logic signed [VW:0]   lim_pos, lim_neg;
  logic signed [VW-1:0] acc;
  logic                 clamped;
  logic signed [VW:0]   diff;
  logic signed [PW-1:0] p_prod, i_prod;
  logic signed [DW-1:0] d_prod;
  logic signed [SW-1:0] sum;
  logic signed [QW-1:0] quot;
  logic signed [OW-1:0] drive;

  always_comb begin
    err_full = (VW+1)'(in_q.setpoint) - (VW+1)'(in_q.measured);
    // The 25-bit difference overflows 24 bits when its top two bits differ.
    if (err_full[VW] != err_full[VW-1]) begin
      err = err_full[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      err = err_full[VW-1:0];
    end

    lim_pos  = $signed({2'b00, integ_limit_q});
    lim_neg  = -lim_pos;
    acc_full = (VW+1)'(integ_q[ch_idx]) + (VW+1)'(err);
    clamped  = 1'b0;
    if (acc_full > lim_pos) begin
      acc     = lim_pos[VW-1:0];
      clamped = 1'b1;
    end else if (acc_full < lim_neg) begin
      acc     = lim_neg[VW-1:0];
      clamped = 1'b1;
    end else begin
      acc = acc_full[VW-1:0];
    end

    diff   = (VW+1)'(err) - (VW+1)'(last_err_q[ch_idx]);
    p_prod = $signed({1'b0, prop_gain_q}) * err;
    i_prod = $signed({1'b0, integ_gain_q}) * acc;
    d_prod = $signed({1'b0, deriv_gain_q}) * diff;
    sum    = SW'(p_prod) + SW'(i_prod) + SW'(d_prod);

    // Dropping the low bits of a two's complement value rounds toward minus infinity.
    quot = sum[SW-1:8];
    if (quot[QW-1:OW-1] != {(QW-OW+1){quot[QW-1]}}) begin
      drive = quot[QW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      drive = quot[OW-1:0];
    end

    out_d.drive         = drive;
    out_d.integ_clamped = clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        last_err_q[k] <= '0;
        integ_q[k]    <= '0;
      end
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        last_err_q[ch_idx] <= err;
        integ_q[ch_idx]    <= acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PID_ASSERT_NEXT(a_beat_moves_out, in_valid_q && advance, out_valid_q, "computed beat was not registered at the output")
  `PID_ASSERT_NEXT(a_stalled_beat_holds, in_valid_q && !advance, in_valid_q && $stable(in_q), "stalled beat in the input register was lost or changed")
  `PID_ASSERT_SAME(a_empty_stage_ready, !in_valid_q, in_ready_o, "input not ready with an empty input register")
  `PID_ASSERT_NEXT(a_clamp_flag, in_valid_q && advance && clamped, out_q.integ_clamped, "clamp flag missing on the output beat")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned HoldCycles    = 40;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned Phases        = 8;
  localparam int unsigned BeatsPerPhase = 80;

  localparam logic signed [pid_pkg::ValueW-1:0] ValMax = 24'h7FFFFF;
  localparam logic signed [pid_pkg::ValueW-1:0] ValMin = 24'h800000;

  // Tracks the gains, the limit and both channels' integral and last error,
  // and keeps the drive values that the block still owes.
  class pid_tracker;
    logic [pid_pkg::GainW-1:0]         kp, ki, kd;
    logic [pid_pkg::LimitW-1:0]        limit;
    logic signed [pid_pkg::ValueW-1:0] last_err[pid_pkg::DefaultChannels];
    logic signed [pid_pkg::ValueW-1:0] integ[pid_pkg::DefaultChannels];
    pid_pkg::pid_out_t                 drive_q[$];
    int unsigned                       mismatches;

    function new();
      kp = pid_pkg::PropGainRst;
      ki = pid_pkg::IntegGainRst;
      kd = pid_pkg::DerivGainRst;
      limit = pid_pkg::IntegLimitRst;
      for (int k = 0; k < pid_pkg::DefaultChannels; k++) begin
        last_err[k] = '0;
        integ[k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(pid_pkg::cfg_idx_e idx, logic [pid_pkg::CfgDataW-1:0] data);
      case (idx)
        pid_pkg::CFG_PROP_GAIN:   kp = data[pid_pkg::GainW-1:0];
        pid_pkg::CFG_INTEG_GAIN:  ki = data[pid_pkg::GainW-1:0];
        pid_pkg::CFG_DERIV_GAIN:  kd = data[pid_pkg::GainW-1:0];
        pid_pkg::CFG_INTEG_LIMIT: limit = data[pid_pkg::LimitW-1:0];
        default: ;
      endcase
    endfunction

    function void predict_drive(pid_pkg::pid_in_t beat);
      int unsigned       ch;
      longint            err, acc, lim, sum, q;
      pid_pkg::pid_out_t want;
      ch = beat.channel % pid_pkg::DefaultChannels;
      err = longint'(beat.setpoint) - longint'(beat.measured);
      if (err > 8388607) err = 8388607;
      if (err < -8388608) err = -8388608;
      lim = longint'(limit);
      acc = longint'(integ[ch]) + err;
      want.integ_clamped = 1'b0;
      if (acc > lim) begin
        acc = lim;
        want.integ_clamped = 1'b1;
      end
      if (acc < -lim) begin
        acc = -lim;
        want.integ_clamped = 1'b1;
      end
      sum = longint'(kp) * err + longint'(ki) * acc
          + longint'(kd) * (err - longint'(last_err[ch]));
      // Arithmetic shift of the exact sum rounds toward minus infinity.
      q = sum >>> 8;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      want.drive = q[pid_pkg::DriveW-1:0];
      last_err[ch] = err[pid_pkg::ValueW-1:0];
      integ[ch] = acc[pid_pkg::ValueW-1:0];
      drive_q.push_back(want);
    endfunction

    function void check_drive(pid_pkg::pid_out_t got);
      pid_pkg::pid_out_t want;
      if (drive_q.size() == 0) begin
        $display("%0t: result with nothing expected, drive %0d clamped %0b",
                 $time, got.drive, got.integ_clamped);
        mismatches++;
        return;
      end
      want = drive_q.pop_front();
      if (got.drive !== want.drive) begin
        $display("%0t: drive expected %0d, actual %0d", $time, want.drive, got.drive);
        mismatches++;
      end
      if (got.integ_clamped !== want.integ_clamped) begin
        $display("%0t: integ_clamped expected %0b, actual %0b",
                 $time, want.integ_clamped, got.integ_clamped);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [pid_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [pid_pkg::CfgDataW-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  pid_pkg::pid_in_t             in_data;
  logic                         out_valid;
  logic                         out_ready;
  pid_pkg::pid_out_t            out_data;

  bit                           quiet;
  bit                           hold_req;
  int unsigned                  idle_cycles = 0;
  pid_tracker                   board = new();

  pid_controller_antiwindup dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        held = 1'b1;
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_drive(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("pid_controller_antiwindup regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_beat(bit ch, logic signed [pid_pkg::ValueW-1:0] meas,
                           logic signed [pid_pkg::ValueW-1:0] setp);
    pid_pkg::pid_in_t beat;
    beat.channel = ch;
    beat.measured = meas;
    beat.setpoint = setp;
    if (!quiet) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    board.predict_drive(beat);
    @(negedge clk);
  endtask

  task automatic write_reg(pid_pkg::cfg_idx_e idx, logic [pid_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.drive_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(logic [pid_pkg::CfgDataW-1:0] p,
                               logic [pid_pkg::CfgDataW-1:0] i,
                               logic [pid_pkg::CfgDataW-1:0] d,
                               logic [pid_pkg::CfgDataW-1:0] lim);
    drain();
    write_reg(pid_pkg::CFG_PROP_GAIN, p);
    write_reg(pid_pkg::CFG_INTEG_GAIN, i);
    write_reg(pid_pkg::CFG_DERIV_GAIN, d);
    write_reg(pid_pkg::CFG_INTEG_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [pid_pkg::CfgDataW-1:0] rand_gain();
    case ($urandom_range(3))
      0:       return pid_pkg::CfgDataW'($urandom_range(512));
      1:       return pid_pkg::CfgDataW'($urandom_range(4096));
      2:       return pid_pkg::CfgDataW'($urandom_range(65535));
      default: return pid_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [pid_pkg::CfgDataW-1:0] rand_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return pid_pkg::CfgDataW'($urandom_range(5000, 1));
      2:       return pid_pkg::CfgDataW'($urandom);
      default: return 23'h7FFFFF;
    endcase
  endfunction

  function automatic logic signed [pid_pkg::ValueW-1:0] rand_value();
    case ($urandom_range(7))
      0, 1, 2: return pid_pkg::ValueW'($urandom);
      3, 4, 5: return pid_pkg::ValueW'($urandom_range(4000)) - 24'd2000;
      6:       return ValMax;
      default: return ValMin;
    endcase
  endfunction

  initial begin
    logic signed [pid_pkg::ValueW-1:0] meas, setp;
    cfg_we = 1'b0;
    cfg_idx = pid_pkg::CFG_PROP_GAIN;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset gains: zero error, error saturation both ways, small errors.
    send_beat(1'b0, '0, '0);
    send_beat(1'b0, ValMin, ValMax);
    send_beat(1'b0, ValMax, ValMin);
    send_beat(1'b1, 24'sd100, 24'sd150);
    send_beat(1'b1, ValMax, ValMax);
    send_beat(1'b1, -24'sd1, 24'sd0);

    // Largest gains (upper data bits must be dropped) and largest limit.
    apply_setting(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
    send_beat(1'b0, ValMin, ValMax);
    send_beat(1'b0, ValMin, ValMax);
    send_beat(1'b0, ValMax, ValMin);
    send_beat(1'b0, ValMax, ValMin);
    send_beat(1'b1, ValMin, ValMax);
    send_beat(1'b1, '0, '0);

    // All zero: the drive is zero and any nonzero integral sum counts as clamped.
    apply_setting('0, '0, '0, '0);
    send_beat(1'b0, '0, 24'sd5);
    send_beat(1'b1, '0, '0);
    send_beat(1'b1, ValMax, ValMin);

    // Unity gains with a zero limit.
    apply_setting(23'd256, 23'd256, 23'd256, '0);
    send_beat(1'b0, 24'sd10, 24'sd3);
    send_beat(1'b0, '0, '0);
    send_beat(1'b1, '0, ValMax);

    for (int ph = 0; ph < Phases; ph++) begin
      apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_limit());
      quiet = (ph == 2);
      for (int n = 0; n < BeatsPerPhase; n++) begin
        if (ph == 5 && n == 20) hold_req = 1'b1;
        meas = rand_value();
        // Half the samples track the setpoint closely so the integral
        // moves inside the limit rather than sitting on it.
        if ($urandom_range(1)) begin
          setp = rand_value();
        end else begin
          setp = meas + pid_pkg::ValueW'($urandom_range(4000)) - 24'd2000;
        end
        send_beat(1'($urandom_range(1)), meas, setp);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (board.drive_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.drive_q.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("pid_controller_antiwindup regression: pass");
    end else begin
      $display("pid_controller_antiwindup regression: fail");
    end
    $finish;
  end

endmodule
